@@ sv/csr_spmv_pkg.sv @@
`default_nettype none

package csr_spmv_pkg;

	// field widths
	localparam int MODE_W      = 2;
	localparam int POS_W       = 10;
	localparam int VALUE_W     = 32;
	localparam int ROW_W       = 16;
	localparam int ACC_W       = 64;
	localparam int CFG_W       = 11;
	localparam int CFG_INDEX_W = 2;

	typedef logic [MODE_W-1:0]      mode_t;
	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
	typedef logic [CFG_W-1:0]       cfg_word_t;

	// item modes
	localparam mode_t MODE_LOAD  = 2'd0;
	localparam mode_t MODE_ENTRY = 2'd1;
	localparam mode_t MODE_EMPTY = 2'd2;

	// register indexes
	localparam cfg_index_t CFG_MATRIX_COLUMNS = 2'd0;
	localparam cfg_index_t CFG_VECTOR_LENGTH  = 2'd1;

	// register reset values
	localparam cfg_word_t MATRIX_COLUMNS_RESET = 11'd1024;
	localparam cfg_word_t VECTOR_LENGTH_RESET  = 11'd1024;

endpackage

`default_nettype wire

@@ sv/csr_spmv_ram.sv @@
`default_nettype none

module csr_spmv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ sv/sparse_csr_matrix_vector_multiply.sv @@
`default_nettype none

// channel   direction  handshake              payload
// item      in         item_valid/item_stall  mode, position, value, row_end
// result    out        result_valid/stall     row_number, row_sum, size_mismatch, saturated
// cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// one item per cycle sustained while item_stall stays low; a result is registered after its
// item transfer through the registered vector store read, the multiplier register,
// the accumulator loop and the rounding stage
// reset clears control state only; the vector store holds nothing until loaded
// result_stall backs up stage by stage; item_stall rises only when all four stages are full

module sparse_csr_matrix_vector_multiply #(
	parameter int VECTOR_DEPTH = 1024
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// item channel
	input  wire logic                                item_valid,
	output logic                                     item_stall,
	input  wire logic [csr_spmv_pkg::MODE_W-1:0]     mode,
	input  wire logic [csr_spmv_pkg::POS_W-1:0]      position,
	input  wire logic signed [csr_spmv_pkg::VALUE_W-1:0] value,
	input  wire logic                                row_end,
	// result channel
	output logic                                     result_valid,
	input  wire logic                                result_stall,
	output logic [csr_spmv_pkg::ROW_W-1:0]           row_number,
	output logic signed [csr_spmv_pkg::VALUE_W-1:0]  row_sum,
	output logic                                     size_mismatch,
	output logic                                     saturated,
	// configuration channel
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [csr_spmv_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [csr_spmv_pkg::CFG_W-1:0]      cfg_data
);

	localparam int AW     = $clog2(VECTOR_DEPTH);
	localparam int VW     = csr_spmv_pkg::VALUE_W;
	localparam int AC     = csr_spmv_pkg::ACC_W;
	localparam int QW     = AC - 15;   // shifted accumulator plus room for the round bit

	// configuration registers
	csr_spmv_pkg::cfg_word_t matrix_columns_q;
	csr_spmv_pkg::cfg_word_t vector_length_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_columns_q <= csr_spmv_pkg::MATRIX_COLUMNS_RESET;
			vector_length_q  <= csr_spmv_pkg::VECTOR_LENGTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				csr_spmv_pkg::CFG_MATRIX_COLUMNS: matrix_columns_q <= cfg_data;
				csr_spmv_pkg::CFG_VECTOR_LENGTH:  vector_length_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage handshake
	logic v_s1, v_s2, v_s3, result_valid_q;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_out;

	assign rdy_out    = !result_valid_q || !result_stall;
	assign rdy_s3     = !v_s3 || rdy_out;
	assign rdy_s2     = !v_s2 || rdy_s3;
	assign rdy_s1     = !v_s1 || rdy_s2;
	assign item_stall = !rdy_s1;

	// input decode
	logic item_xfer, is_load, is_entry, is_empty, pos_in_depth, col_ok;

	assign item_xfer    = item_valid && !item_stall;
	assign is_load      = mode == csr_spmv_pkg::MODE_LOAD;
	assign is_entry     = mode == csr_spmv_pkg::MODE_ENTRY;
	assign is_empty     = mode == csr_spmv_pkg::MODE_EMPTY;
	assign pos_in_depth = 32'(position) < 32'(VECTOR_DEPTH);
	assign col_ok       = pos_in_depth && ({1'b0, position} < matrix_columns_q);

	// vector store
	logic [VW-1:0] elem_raw;

	csr_spmv_ram #(
		.WIDTH(VW),
		.DEPTH(VECTOR_DEPTH)
	) u_vector_store (
		.clk    (clk),
		.wr_en  (item_xfer && is_load && pos_in_depth),
		.wr_addr(AW'(position)),
		.wr_data(value),
		.rd_en  (item_xfer && is_entry),
		.rd_addr(AW'(position)),
		.rd_data(elem_raw)
	);

	// stage 1: store read in flight
	logic              empty_s1, last_s1, inrange_s1;
	logic signed [VW-1:0] value_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= item_xfer && (is_entry || is_empty);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && item_xfer) begin
			empty_s1   <= is_empty;
			last_s1    <= row_end;
			inrange_s1 <= col_ok;
			value_s1   <= value;
		end
	end

	// stage 2: product register
	logic signed [VW-1:0] elem;
	logic signed [AC-1:0] prod_s2;
	logic                 empty_s2, last_s2;

	assign elem = inrange_s1 ? $signed(elem_raw) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			prod_s2  <= value_s1 * elem;
			empty_s2 <= empty_s1;
			last_s2  <= last_s1;
		end
	end

	// stage 3: saturating row accumulator
	logic signed [AC-1:0] acc_q, acc_sum, acc_next;
	logic                 clip_q, ovf_pos, ovf_neg, clip_next;
	logic signed [AC-1:0] fin_acc_s3;
	logic                 fin_clip_s3, empty_s3;
	logic                 s2_xfer;

	assign acc_sum   = acc_q + prod_s2;
	assign ovf_pos   = !acc_q[AC-1] && !prod_s2[AC-1] && acc_sum[AC-1];
	assign ovf_neg   = acc_q[AC-1] && prod_s2[AC-1] && !acc_sum[AC-1];
	assign acc_next  = ovf_pos ? {1'b0, {(AC-1){1'b1}}} :
	                   ovf_neg ? {1'b1, {(AC-1){1'b0}}} : acc_sum;
	assign clip_next = clip_q || ovf_pos || ovf_neg;
	assign s2_xfer   = rdy_s3 && v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3   <= 1'b0;
			acc_q  <= '0;
			clip_q <= 1'b0;
		end else begin
			if (rdy_s3) begin
				v_s3 <= v_s2 && (empty_s2 || last_s2);
			end
			// empty rows leave a pending partial row alone
			if (s2_xfer && !empty_s2) begin
				if (last_s2) begin
					acc_q  <= '0;
					clip_q <= 1'b0;
				end else begin
					acc_q  <= acc_next;
					clip_q <= clip_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_xfer) begin
			fin_acc_s3  <= acc_next;
			fin_clip_s3 <= clip_next;
			empty_s3    <= empty_s2;
		end
	end

	// output stage: round half up to Q16.16 and saturate
	logic signed [QW-1:0] q_round;
	logic                 q_fits, mismatch;
	logic signed [VW-1:0] q_sat;
	logic [csr_spmv_pkg::ROW_W-1:0] row_cnt_q, row_number_q;
	logic signed [VW-1:0] row_sum_q;
	logic                 size_mismatch_q, saturated_q;

	assign q_round  = $signed({fin_acc_s3[AC-1], fin_acc_s3[AC-1:16]})
	                + $signed({{(QW-1){1'b0}}, fin_acc_s3[15]});
	assign q_fits   = (&q_round[QW-1:VW-1]) || !(|q_round[QW-1:VW-1]);
	assign q_sat    = q_fits ? q_round[VW-1:0] :
	                  q_round[QW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
	assign mismatch = matrix_columns_q != vector_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			row_cnt_q      <= '0;
		end else if (rdy_out) begin
			result_valid_q <= v_s3;
			if (v_s3) begin
				row_cnt_q <= row_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && v_s3) begin
			row_number_q    <= row_cnt_q;
			size_mismatch_q <= mismatch;
			if (mismatch || empty_s3) begin
				row_sum_q   <= '0;
				saturated_q <= 1'b0;
			end else begin
				row_sum_q   <= q_sat;
				saturated_q <= fin_clip_s3 || !q_fits;
			end
		end
	end

	assign result_valid  = result_valid_q;
	assign row_number    = row_number_q;
	assign row_sum       = row_sum_q;
	assign size_mismatch = size_mismatch_q;
	assign saturated     = saturated_q;

endmodule

`default_nettype wire

@@ sv/csr_spmv_checker.sv @@
`default_nettype none

module csr_spmv_checker (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 item_valid,
	input wire logic                                 item_stall,
	input wire logic [csr_spmv_pkg::MODE_W-1:0]      mode,
	input wire logic                                 row_end,
	input wire logic                                 result_valid,
	input wire logic                                 result_stall,
	input wire logic [csr_spmv_pkg::ROW_W-1:0]       row_number,
	input wire logic signed [csr_spmv_pkg::VALUE_W-1:0] row_sum,
	input wire logic                                 size_mismatch,
	input wire logic                                 saturated
);

	logic                            item_xfer, result_xfer, makes_result;
	logic [2:0]                      pending_q;
	logic [csr_spmv_pkg::ROW_W-1:0]  expect_row_q;

	assign item_xfer    = item_valid && !item_stall;
	assign result_xfer  = result_valid && !result_stall;
	assign makes_result = item_xfer && ((mode == csr_spmv_pkg::MODE_ENTRY && row_end)
	                                  || mode == csr_spmv_pkg::MODE_EMPTY);

	// rows in flight and the row number due next
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q    <= '0;
			expect_row_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(makes_result) - 3'(result_xfer);
			if (result_xfer) begin
				expect_row_q <= expect_row_q + 1'b1;
			end
		end
	end

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(row_sum)
			&& $stable(row_number))
	else $error("stalled result changed");

	// rows come out in order, none skipped
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> row_number == expect_row_q)
	else $error("row number out of sequence");

	// no result without a row-closing item behind it
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pending_q != 3'd0)
	else $error("result with no row in flight");

	// a size mismatch forces a clean zero
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && size_mismatch |-> row_sum == '0 && !saturated)
	else $error("mismatch result not zero");

endmodule

bind sparse_csr_matrix_vector_multiply csr_spmv_checker u_checker (.*);

`default_nettype wire

@@ tb/sv/tb.sv @@
module tb;

	localparam int VECTOR_DEPTH = 1024;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int LONG_HOLD    = 100;
	localparam int SETTLE       = 8;
	localparam int REPORT_CAP   = 200;

	localparam csr_spmv_pkg::mode_t      MODE_UNUSED    = 2'd3;
	localparam csr_spmv_pkg::cfg_index_t CFG_RESERVED_A = 2'd2;
	localparam csr_spmv_pkg::cfg_index_t CFG_RESERVED_B = 2'd3;

	localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint ACC_MIN = -ACC_MAX - 1;
	localparam longint SUM_MAX = 64'sd2147483647;
	localparam longint SUM_MIN = -SUM_MAX - 1;

	typedef struct packed {
		csr_spmv_pkg::mode_t                     mode;
		logic [csr_spmv_pkg::POS_W-1:0]          position;
		logic signed [csr_spmv_pkg::VALUE_W-1:0] value;
		logic                                    row_end;
	} item_t;

	typedef struct packed {
		logic [csr_spmv_pkg::ROW_W-1:0]          row_number;
		logic signed [csr_spmv_pkg::VALUE_W-1:0] row_sum;
		logic                                    size_mismatch;
		logic                                    saturated;
	} row_result_t;

	logic clk;
	logic arst_n;

	logic                                    item_valid = 1'b0;
	logic                                    item_stall;
	csr_spmv_pkg::mode_t                     mode = csr_spmv_pkg::MODE_LOAD;
	logic [csr_spmv_pkg::POS_W-1:0]          position = '0;
	logic signed [csr_spmv_pkg::VALUE_W-1:0] value = '0;
	logic                                    row_end = 1'b0;

	logic                                    result_valid;
	logic                                    result_stall = 1'b0;
	logic [csr_spmv_pkg::ROW_W-1:0]          row_number;
	logic signed [csr_spmv_pkg::VALUE_W-1:0] row_sum;
	logic                                    size_mismatch;
	logic                                    saturated;

	logic                     cfg_valid;
	logic                     cfg_ready;
	csr_spmv_pkg::cfg_index_t cfg_index;
	csr_spmv_pkg::cfg_word_t  cfg_data;

	// items waiting to go out and rows still owed by the block
	item_t       pending_items[$];
	row_result_t expected_rows[$];
	item_t       next_item;
	row_result_t want;

	// shadow of the block's state and registers
	logic signed [csr_spmv_pkg::VALUE_W-1:0] vector_image [VECTOR_DEPTH];
	longint                                  row_acc = 0;
	logic [csr_spmv_pkg::ROW_W-1:0]          rows_done = '0;
	bit                                      clip_flag = 1'b0;
	csr_spmv_pkg::cfg_word_t                 matrix_cols;
	csr_spmv_pkg::cfg_word_t                 vector_len;

	// positions already loaded, as seen by the stimulus
	bit stored [VECTOR_DEPTH];
	int stored_list[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;
	int failures = 0;
	int cycle_count = 0;

	sparse_csr_matrix_vector_multiply #(
		.VECTOR_DEPTH(VECTOR_DEPTH)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.mode         (mode),
		.position     (position),
		.value        (value),
		.row_end      (row_end),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.row_number   (row_number),
		.row_sum      (row_sum),
		.size_mismatch(size_mismatch),
		.saturated    (saturated),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// finished row: forced to zero when the sizes disagree
	function automatic void post_row(logic signed [csr_spmv_pkg::VALUE_W-1:0] sum,
			bit clipped);
		row_result_t res;
		bit mism;
		mism = matrix_cols != vector_len;
		res.row_number    = rows_done;
		res.row_sum       = mism ? '0 : sum;
		res.size_mismatch = mism;
		res.saturated     = !mism && clipped;
		expected_rows.push_back(res);
		rows_done++;
	endfunction

	// behaviour of one accepted item
	function automatic void apply_item(csr_spmv_pkg::mode_t m,
			logic [csr_spmv_pkg::POS_W-1:0] p,
			logic signed [csr_spmv_pkg::VALUE_W-1:0] v, logic last);
		longint elem;
		longint product;
		longint total;
		longint q;
		bit clip;
		case (m)
			csr_spmv_pkg::MODE_LOAD: begin
				vector_image[p] = v;
			end
			csr_spmv_pkg::MODE_ENTRY: begin
				elem = 0;
				if (p < matrix_cols)
					elem = longint'(vector_image[p]);
				product = longint'(v) * elem;
				total = row_acc + product;
				if (row_acc >= 0 && product >= 0 && total < 0) begin
					total = ACC_MAX;
					clip_flag = 1'b1;
				end else if (row_acc < 0 && product < 0 && total >= 0) begin
					total = ACC_MIN;
					clip_flag = 1'b1;
				end
				row_acc = total;
				if (last) begin
					// q32.32 to q16.16, half rounds upwards, then clip to 32 bits
					clip = clip_flag;
					q = (row_acc >>> 16) + (row_acc[15] ? 1 : 0);
					if (q > SUM_MAX) begin
						q = SUM_MAX;
						clip = 1'b1;
					end else if (q < SUM_MIN) begin
						q = SUM_MIN;
						clip = 1'b1;
					end
					post_row(q[csr_spmv_pkg::VALUE_W-1:0], clip);
					row_acc = 0;
					clip_flag = 1'b0;
				end
			end
			csr_spmv_pkg::MODE_EMPTY: begin
				post_row('0, 1'b0);
			end
			default: ;
		endcase
	endfunction

	function automatic void queue_item(csr_spmv_pkg::mode_t m, int p,
			logic signed [csr_spmv_pkg::VALUE_W-1:0] v, bit last);
		item_t it;
		it.mode     = m;
		it.position = p[csr_spmv_pkg::POS_W-1:0];
		it.value    = v;
		it.row_end  = last;
		if (m == csr_spmv_pkg::MODE_LOAD && !stored[it.position]) begin
			stored[it.position] = 1'b1;
			stored_list.push_back(it.position);
		end
		pending_items.push_back(it);
	endfunction

	// mix of full-range, small fractional and corner values
	function automatic logic signed [csr_spmv_pkg::VALUE_W-1:0] pick_value();
		logic signed [csr_spmv_pkg::VALUE_W-1:0] v;
		case ($urandom_range(3))
			0: v = $urandom;
			1: v = int'($urandom_range(262144)) - 131072;
			2: v = int'($urandom_range(16777216)) - 8388608;
			default: begin
				case ($urandom_range(4))
					0: v = 32'sh8000_0000;
					1: v = 32'sh7FFF_FFFF;
					2: v = 32'sh0001_0000;
					3: v = 32'shFFFF_0000;
					default: v = '0;
				endcase
			end
		endcase
		return v;
	endfunction

	// only loaded positions, mostly inside the column count
	function automatic int pick_column();
		int p;
		p = stored_list[$urandom_range(stored_list.size() - 1)];
		for (int k = 0; k < 8 && p >= matrix_cols; k++)
			p = stored_list[$urandom_range(stored_list.size() - 1)];
		return p;
	endfunction

	// well-formed rows with some loads, empty rows, lone entries and noise
	task automatic random_traffic(int count);
		int n;
		int roll;
		int len;
		int p;
		n = 0;
		while (n < count) begin
			roll = $urandom_range(99);
			if (roll < 15) begin
				if ($urandom_range(9) < 4)
					p = $urandom_range(int'(matrix_cols) - 1);
				else
					p = $urandom_range(VECTOR_DEPTH - 1);
				queue_item(csr_spmv_pkg::MODE_LOAD, p, pick_value(), $urandom_range(1));
				n++;
			end else if (roll < 23) begin
				queue_item(csr_spmv_pkg::MODE_EMPTY, $urandom_range(VECTOR_DEPTH - 1),
					pick_value(), $urandom_range(1));
				n++;
			end else if (roll < 27) begin
				queue_item(MODE_UNUSED, $urandom_range(VECTOR_DEPTH - 1), pick_value(),
					$urandom_range(1));
			end else if (roll < 32) begin
				queue_item(csr_spmv_pkg::MODE_ENTRY, pick_column(), pick_value(), 1'b0);
				n++;
			end else begin
				len = $urandom_range(1, 6);
				for (int k = 0; k < len; k++)
					queue_item(csr_spmv_pkg::MODE_ENTRY, pick_column(), pick_value(),
						k == len - 1);
				n += len;
			end
		end
	endtask

	// wait until everything has gone through, then let the pipeline settle
	task automatic drain();
		while (pending_items.size() != 0 || item_valid || expected_rows.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_register(csr_spmv_pkg::cfg_index_t idx,
			csr_spmv_pkg::cfg_word_t data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == csr_spmv_pkg::CFG_MATRIX_COLUMNS)
			matrix_cols = data;
		else if (idx == csr_spmv_pkg::CFG_VECTOR_LENGTH)
			vector_len = data;
		cfg_valid <= 1'b0;
	endtask

	task automatic set_sizes(int cols, int len);
		write_register(csr_spmv_pkg::CFG_MATRIX_COLUMNS, cols[csr_spmv_pkg::CFG_W-1:0]);
		write_register(csr_spmv_pkg::CFG_VECTOR_LENGTH, len[csr_spmv_pkg::CFG_W-1:0]);
	endtask

	// item driver
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall)
				apply_item(mode, position, value, row_end);
			if (!item_valid || !item_stall) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_item = pending_items.pop_front();
					item_valid <= 1'b1;
					mode       <= next_item.mode;
					position   <= next_item.position;
					value      <= next_item.value;
					row_end    <= next_item.row_end;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// result receiver, with an occasional long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (holds_served != hold_requests) begin
			holds_served <= holds_served + 1;
			hold_left    <= LONG_HOLD;
			result_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= $urandom_range(99) < recv_stall_pct;
		end
	end

	task automatic check_field(string name, longint expected, longint actual);
		if (expected != actual) begin
			if (failures < REPORT_CAP)
				$error("%s: expected %0d, got %0d", name, expected, actual);
			failures++;
		end
	endtask

	// result monitor: each transfer against the oldest expected row
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_rows.size() == 0) begin
				if (failures < REPORT_CAP)
					$error("unexpected row result: row_number %0d, row_sum %0d",
						row_number, row_sum);
				failures++;
			end else begin
				want = expected_rows.pop_front();
				check_field("row_number", want.row_number, row_number);
				check_field("row_sum", longint'(want.row_sum), longint'(row_sum));
				check_field("size_mismatch", want.size_mismatch, size_mismatch);
				check_field("saturated", want.saturated, saturated);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = csr_spmv_pkg::CFG_MATRIX_COLUMNS;
		cfg_data    = '0;
		matrix_cols = csr_spmv_pkg::MATRIX_COLUMNS_RESET;
		vector_len  = csr_spmv_pkg::VECTOR_LENGTH_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// corner loads, then rounding and saturation in both directions
		queue_item(csr_spmv_pkg::MODE_LOAD, 0, 32'sh0000_0001, 1'b0);
		queue_item(csr_spmv_pkg::MODE_LOAD, VECTOR_DEPTH - 1, 32'sh8000_0000, 1'b1);
		queue_item(csr_spmv_pkg::MODE_LOAD, 1, 32'sh7FFF_FFFF, 1'b0);
		queue_item(csr_spmv_pkg::MODE_LOAD, 2, 32'sh0001_0000, 1'b0);
		queue_item(csr_spmv_pkg::MODE_ENTRY, 0, 32'sh0000_8000, 1'b1);
		queue_item(csr_spmv_pkg::MODE_ENTRY, 0, -32'sh0000_8000, 1'b1);
		for (int k = 0; k < 4; k++)
			queue_item(csr_spmv_pkg::MODE_ENTRY, VECTOR_DEPTH - 1, 32'sh8000_0000, k == 3);
		for (int k = 0; k < 3; k++)
			queue_item(csr_spmv_pkg::MODE_ENTRY, VECTOR_DEPTH - 1, 32'sh7FFF_FFFF, k == 2);
		// empty row in the middle of a partial row
		queue_item(csr_spmv_pkg::MODE_ENTRY, 2, 32'sh0003_0000, 1'b0);
		queue_item(csr_spmv_pkg::MODE_EMPTY, 0, '0, 1'b0);
		queue_item(csr_spmv_pkg::MODE_ENTRY, 2, 32'sh0001_0000, 1'b1);
		queue_item(MODE_UNUSED, VECTOR_DEPTH - 1, 32'sh7FFF_FFFF, 1'b1);
		// output rounding alone clips
		queue_item(csr_spmv_pkg::MODE_ENTRY, 1, 32'sh7FFF_FFFF, 1'b1);
		drain();

		// writes to unmapped indexes change nothing
		write_register(CFG_RESERVED_A, 11'd5);
		write_register(CFG_RESERVED_B, 11'd2047);

		// columns beyond the matrix add nothing, row end still counts
		set_sizes(2, 2);
		queue_item(csr_spmv_pkg::MODE_ENTRY, VECTOR_DEPTH - 1, 32'sh0001_0000, 1'b0);
		queue_item(csr_spmv_pkg::MODE_ENTRY, 2, 32'sh0001_0000, 1'b0);
		queue_item(csr_spmv_pkg::MODE_ENTRY, 0, 32'sh0001_0000, 1'b1);
		drain();

		// mismatched sizes force zero rows
		set_sizes(1024, 0);
		queue_item(csr_spmv_pkg::MODE_ENTRY, 1, 32'sh7FFF_FFFF, 1'b1);
		queue_item(csr_spmv_pkg::MODE_EMPTY, 0, '0, 1'b1);
		drain();

		// free-running, no idling
		set_sizes(1024, 1024);
		random_traffic(130);
		drain();

		// sender idling, with a pause until every row is back
		set_sizes(16, 16);
		send_idle_pct = 65;
		random_traffic(65);
		drain();
		random_traffic(65);
		drain();

		// receiver stalling, single column against a long vector
		set_sizes(1, 1024);
		send_idle_pct = 0;
		recv_stall_pct = 65;
		random_traffic(130);
		drain();

		// light idling on both sides, off-by-one mismatch
		set_sizes(700, 699);
		send_idle_pct = 6;
		recv_stall_pct = 6;
		random_traffic(130);
		drain();

		// long hold-off so the pipeline fills and pushes back on the sender
		set_sizes(300, 300);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_requests++;
		random_traffic(130);
		drain();

		repeat (SETTLE) @(posedge clk);
		if (failures == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
